@@ hdl/bgd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bgd_pkg;

  localparam int unsigned TimerW   = 32;
  localparam int unsigned ValW     = 16;
  localparam int unsigned CodeW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned NumSlots = 4;

  localparam int unsigned SlotDeb   = 0;
  localparam int unsigned SlotClick = 1;
  localparam int unsigned SlotLong  = 2;
  localparam int unsigned SlotRep   = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIN_MASK        = 3'd0,
    CFG_ACTIVE_HIGH     = 3'd1,
    CFG_DEBOUNCE_TIME   = 3'd2,
    CFG_DOUBLE_WINDOW   = 3'd3,
    CFG_LONG_PRESS_TIME = 3'd4,
    CFG_REPEAT_DELAY    = 3'd5,
    CFG_REPEAT_INTERVAL = 3'd6
  } cfg_idx_e;

  typedef enum logic [CodeW-1:0] {
    EV_RELEASE  = 3'd0,
    EV_PRESS    = 3'd1,
    EV_CLICK    = 3'd2,
    EV_DCLICK   = 3'd3,
    EV_LONG     = 3'd4,
    EV_DLONG    = 3'd5,
    EV_REPEAT   = 3'd6,
    EV_DREPEAT  = 3'd7
  } ev_code_e;

  typedef enum logic [2:0] {
    LVL_UNKNOWN  = 3'b001,
    LVL_RELEASED = 3'b010,
    LVL_PRESSED  = 3'b100
  } lvl_e;

  typedef struct packed {
    logic [ValW-1:0] pin_mask;
    logic            active_high;
    logic [ValW-1:0] debounce_time;
    logic [ValW-1:0] double_window;
    logic [ValW-1:0] long_press_time;
    logic [ValW-1:0] repeat_delay;
    logic [ValW-1:0] repeat_interval;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    pin_mask:        16'd1,
    active_high:     1'b1,
    debounce_time:   16'd40,
    double_window:   16'd400,
    long_press_time: 16'd500,
    repeat_delay:    16'd1500,
    repeat_interval: 16'd500
  };

  typedef struct packed {
    logic [NumSlots-1:0]            vld;
    logic [NumSlots-1:0][CodeW-1:0] code;
  } ev_set_t;

endpackage

`default_nettype wire

@@ hdl/bgd_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bgd_cfg_if
  import bgd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ValW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/bgd_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bgd_in_if
  import bgd_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [ValW-1:0] elapsed;
  logic [ValW-1:0] port_value;

  modport source (output valid, elapsed, port_value, input ready);
  modport sink   (input valid, elapsed, port_value, output ready);
endinterface

`default_nettype wire

@@ hdl/bgd_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bgd_out_if
  import bgd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] event_code;
  logic             last_event;

  modport source (output valid, event_code, last_event, input ready);
  modport sink   (input valid, event_code, last_event, output ready);
endinterface

`default_nettype wire

@@ hdl/bgd_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bgd_cfg_regs
  import bgd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bgd_cfg_if.sink    cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_PIN_MASK:        cfg_d.pin_mask        = cfg_i.data;
        CFG_ACTIVE_HIGH:     cfg_d.active_high     = cfg_i.data[0];
        CFG_DEBOUNCE_TIME:   cfg_d.debounce_time   = cfg_i.data;
        CFG_DOUBLE_WINDOW:   cfg_d.double_window   = cfg_i.data;
        CFG_LONG_PRESS_TIME: cfg_d.long_press_time = cfg_i.data;
        CFG_REPEAT_DELAY:    cfg_d.repeat_delay    = cfg_i.data;
        CFG_REPEAT_INTERVAL: cfg_d.repeat_interval = cfg_i.data;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bgd_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bgd_core
  import bgd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bgd_in_if.sink     in_i,
  input  wire cfg_t  cfg_i,
  input  wire logic  free_i,
  output logic       load_o,
  output ev_set_t    ev_o
);

  logic              in_vld_q, in_vld_d;
  logic [ValW-1:0]   elapsed_q;
  logic [ValW-1:0]   port_q;

  lvl_e              lvl_q;
  logic [TimerW-1:0] lt_q, lt_d;
  logic [TimerW-1:0] pt_q, pt_d;
  logic              df_q, df_d;

  logic              pressed;
  logic              press_hit;
  lvl_e              cur_lvl;

  assign load_o     = in_vld_q && free_i;
  assign in_i.ready = !in_vld_q || load_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_i.valid && in_i.ready) begin
      in_vld_d = 1'b1;
    end else if (load_o) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    logic [TimerW-1:0] dt, deb, dw, lp, rd, ri;
    logic [TimerW-1:0] lt_cur, lt_prev, pt_sum, pt_cur, pt_prev;
    logic              deb_hit, click_hit, long_hit, rep_hit;

    dt  = {{(TimerW-ValW){1'b0}}, elapsed_q};
    deb = {{(TimerW-ValW){1'b0}}, cfg_i.debounce_time};
    dw  = {{(TimerW-ValW){1'b0}}, cfg_i.double_window};
    lp  = {{(TimerW-ValW){1'b0}}, cfg_i.long_press_time};
    rd  = {{(TimerW-ValW){1'b0}}, cfg_i.repeat_delay};
    ri  = {{(TimerW-ValW){1'b0}}, cfg_i.repeat_interval};

    pressed = cfg_i.active_high ? (|(port_q & cfg_i.pin_mask))
                                : !(|(port_q & cfg_i.pin_mask));
    cur_lvl = pressed ? LVL_PRESSED : LVL_RELEASED;

    if (lvl_q != cur_lvl) begin
      lt_cur  = (lvl_q == LVL_UNKNOWN) ? deb + {{(TimerW-1){1'b0}}, 1'b1} : '0;
      lt_prev = lt_cur - dt;
    end else begin
      lt_cur  = lt_q + dt;
      lt_prev = lt_q;
    end

    pt_sum    = pt_q + dt;
    deb_hit   = (lt_prev < deb) && (lt_cur >= deb);
    press_hit = deb_hit && pressed;
    df_d      = press_hit ? (pt_sum < dw) : df_q;
    pt_cur    = press_hit ? '0 : pt_sum;
    pt_prev   = press_hit ? ('0 - dt) : pt_q;
    pt_d      = pt_cur;

    click_hit = (pt_prev < dw) && (pt_cur >= dw) && (lt_cur < dw);
    long_hit  = pressed && (lt_prev < lp) && (lt_cur >= lp);
    rep_hit   = pressed && (lt_cur > rd);
    lt_d      = rep_hit ? lt_cur - ri : lt_cur;

    ev_o.vld                  = '0;
    ev_o.vld[SlotDeb]         = deb_hit;
    ev_o.vld[SlotClick]       = click_hit;
    ev_o.vld[SlotLong]        = long_hit;
    ev_o.vld[SlotRep]         = rep_hit;
    ev_o.code                 = '0;
    ev_o.code[SlotDeb]        = pressed ? EV_PRESS : EV_RELEASE;
    ev_o.code[SlotClick]      = df_d ? EV_DCLICK : EV_CLICK;
    ev_o.code[SlotLong]       = df_d ? EV_DLONG : EV_LONG;
    ev_o.code[SlotRep]        = df_d ? EV_DREPEAT : EV_REPEAT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      lvl_q    <= LVL_UNKNOWN;
      lt_q     <= '0;
      pt_q     <= '0;
      df_q     <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
      if (load_o) begin
        lvl_q <= cur_lvl;
        lt_q  <= lt_d;
        pt_q  <= pt_d;
        df_q  <= df_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      elapsed_q <= in_i.elapsed;
      port_q    <= in_i.port_value;
    end
  end

`ifndef SYNTHESIS
  a_level_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o |=> (lvl_q != LVL_UNKNOWN))
    else $error("level still unknown after a tick");

  a_press_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_o && press_hit) |=> (pt_q == '0))
    else $error("press timer not cleared on press");
`endif

endmodule

`default_nettype wire

@@ hdl/bgd_evq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bgd_evq
  import bgd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire ev_set_t ev_i,
  output logic         free_o,
  bgd_out_if.source    out_o
);

  logic [NumSlots-1:0]            vld_q, vld_d;
  logic [NumSlots-1:0][CodeW-1:0] code_q;
  logic [NumSlots-1:0]            sel_oh;
  logic [CodeW-1:0]               sel_code;
  logic                           single;
  logic                           pop;

  assign sel_oh = vld_q & ~(vld_q - {{(NumSlots-1){1'b0}}, 1'b1});
  assign single = (vld_q != '0) && ((vld_q & (vld_q - {{(NumSlots-1){1'b0}}, 1'b1})) == '0);
  assign pop    = out_o.valid && out_o.ready;
  assign free_o = (vld_q == '0) || (out_o.ready && single);

  always_comb begin
    sel_code = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (sel_oh[i]) begin
        sel_code = sel_code | code_q[i];
      end
    end
  end

  assign out_o.valid      = |vld_q;
  assign out_o.event_code = sel_code;
  assign out_o.last_event = single;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = ev_i.vld;
    end else if (pop) begin
      vld_d = vld_q & ~sel_oh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      code_q <= ev_i.code;
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ((vld_q == '0) || (out_o.ready && single)))
    else $error("event set loaded over pending items");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (vld_q == $past(vld_q)))
    else $error("pending events changed during stall");

  a_pop_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !single) |=> ($countones(vld_q) == $countones($past(vld_q)) - 1))
    else $error("pop did not drop exactly one event");
`endif

endmodule

`default_nettype wire

@@ hdl/button_gesture_detector_unit.sv @@
// Button gesture detector.
// cfg_i: register writes (index, data), always ready; write only while idle.
// in_i: one tick per item (elapsed time, sampled port word).
// out_o: one event per item (event_code, last_event); last_event marks the
//   final event of a tick. A tick yields zero to four events.
// An accepted tick sits in the input register while its events and the new
// timer state are computed; they are loaded into the event buffer once it is
// free, and the buffer then offers the first event to the receiver.
// The event buffer drains one event per cycle while the receiver is ready;
// ticks without events stream at one per cycle while the buffer is empty.
// A new tick is taken while the last event of the previous one is being
// handed off.
// A stalled receiver holds the current event; the input register fills
// and in_i.ready drops until the buffer frees.
// Reset restores the register defaults, clears all timers and flags, sets
// the level to unknown and empties both stages.
`timescale 1ns / 1ps
`default_nettype none

module button_gesture_detector_unit
  import bgd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bgd_cfg_if.sink    cfg_i,
  bgd_in_if.sink     in_i,
  bgd_out_if.source  out_o
);

  cfg_t    cfg;
  logic    load;
  logic    free;
  ev_set_t ev_set;

  bgd_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bgd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg),
    .free_i (free),
    .load_o (load),
    .ev_o   (ev_set)
  );

  bgd_evq u_evq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .ev_i   (ev_set),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/button_gesture_detector_unit_test.sv @@
`timescale 1ns / 1ps

module button_gesture_detector_unit_test;
  import bgd_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;
  localparam int unsigned TicksPerPhase = 65;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles = 70;
  localparam int unsigned HoldAtTick = 240;
  localparam int unsigned WatchdogLimit = 3000;

  typedef struct packed {
    ev_code_e code;
    logic     last_ev;
  } gesture_t;

  typedef struct packed {
    logic [ValW-1:0] elapsed;
    logic [ValW-1:0] port;
    logic            typed;
    logic [2:0]      n_typed;
    ev_code_e        first_ev;
  } tick_row_t;

  localparam int unsigned NumDirected = 20;
  localparam tick_row_t DirectedTicks [NumDirected] = '{
    '{16'd65535, 16'h0001, 1'b1, 3'd1, EV_CLICK},
    '{16'd0,     16'h0001, 1'b1, 3'd0, EV_RELEASE},
    '{16'd10,    16'hFFFE, 1'b0, 3'd0, EV_RELEASE},
    '{16'd50,    16'hFFFE, 1'b0, 3'd0, EV_RELEASE},
    '{16'd400,   16'h0000, 1'b0, 3'd0, EV_RELEASE},
    '{16'd5,     16'hFFFF, 1'b0, 3'd0, EV_RELEASE},
    '{16'd45,    16'h0001, 1'b0, 3'd0, EV_RELEASE},
    '{16'd20,    16'h0000, 1'b0, 3'd0, EV_RELEASE},
    '{16'd60,    16'h0000, 1'b0, 3'd0, EV_RELEASE},
    '{16'd10,    16'h0001, 1'b0, 3'd0, EV_RELEASE},
    '{16'd50,    16'h0001, 1'b0, 3'd0, EV_RELEASE},
    '{16'd600,   16'h0001, 1'b0, 3'd0, EV_RELEASE},
    '{16'd1000,  16'h0001, 1'b0, 3'd0, EV_RELEASE},
    '{16'd0,     16'h0001, 1'b0, 3'd0, EV_RELEASE},
    '{16'd65535, 16'hFFFF, 1'b0, 3'd0, EV_RELEASE},
    '{16'd100,   16'h0000, 1'b0, 3'd0, EV_RELEASE},
    '{16'd100,   16'h0000, 1'b0, 3'd0, EV_RELEASE},
    '{16'd400,   16'h0000, 1'b0, 3'd0, EV_RELEASE},
    '{16'd65535, 16'hFFFE, 1'b0, 3'd0, EV_RELEASE},
    '{16'd1,     16'h8001, 1'b0, 3'd0, EV_RELEASE}
  };

  localparam logic [CfgIdxW-1:0] RegOrder [8] = '{
    CFG_PIN_MASK, CFG_ACTIVE_HIGH, CFG_DEBOUNCE_TIME, CFG_DOUBLE_WINDOW,
    CFG_LONG_PRESS_TIME, CFG_REPEAT_DELAY, CFG_REPEAT_INTERVAL, CfgIdxUnused
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bgd_cfg_if cfg_if ();
  bgd_in_if in_if ();
  bgd_out_if out_if ();

  button_gesture_detector_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cfg_t        regs = CfgReset;
  lvl_e        btn_level = LVL_UNKNOWN;
  logic [31:0] level_time = '0;
  logic [31:0] press_time = '0;
  logic        dbl_press = 1'b0;
  ev_code_e    tick_ev [4];

  gesture_t    pending_events [$];
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  bit          calm = 1'b0;

  function automatic bit crossed(logic [31:0] t, logic [31:0] dt, logic [ValW-1:0] lim);
    logic [31:0] diff;
    diff = t - dt;
    return (diff < {16'd0, lim}) && (t >= {16'd0, lim});
  endfunction

  function automatic int gesture_step(logic [ValW-1:0] elapsed, logic [ValW-1:0] port);
    logic [31:0] dt;
    logic        pressed;
    lvl_e        cur;
    int          n;
    dt = {16'd0, elapsed};
    pressed = regs.active_high ? |(port & regs.pin_mask) : ~|(port & regs.pin_mask);
    cur = pressed ? LVL_PRESSED : LVL_RELEASED;
    n = 0;
    if (btn_level != cur) begin
      level_time = (btn_level == LVL_UNKNOWN) ? {16'd0, regs.debounce_time} + 32'd1 : 32'd0;
      btn_level = cur;
    end else begin
      level_time += dt;
    end
    press_time += dt;
    if (crossed(level_time, dt, regs.debounce_time)) begin
      tick_ev[n] = pressed ? EV_PRESS : EV_RELEASE;
      n++;
      if (pressed) begin
        dbl_press = press_time < {16'd0, regs.double_window};
        press_time = '0;
      end
    end
    if (crossed(press_time, dt, regs.double_window) &&
        level_time < {16'd0, regs.double_window}) begin
      tick_ev[n] = dbl_press ? EV_DCLICK : EV_CLICK;
      n++;
    end
    if (btn_level == LVL_PRESSED) begin
      if (crossed(level_time, dt, regs.long_press_time)) begin
        tick_ev[n] = dbl_press ? EV_DLONG : EV_LONG;
        n++;
      end
      if (level_time > {16'd0, regs.repeat_delay}) begin
        tick_ev[n] = dbl_press ? EV_DREPEAT : EV_REPEAT;
        n++;
        level_time -= {16'd0, regs.repeat_interval};
      end
    end
    return n;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [ValW-1:0] data);
    case (idx)
      CFG_PIN_MASK:        regs.pin_mask = data;
      CFG_ACTIVE_HIGH:     regs.active_high = data[0];
      CFG_DEBOUNCE_TIME:   regs.debounce_time = data;
      CFG_DOUBLE_WINDOW:   regs.double_window = data;
      CFG_LONG_PRESS_TIME: regs.long_press_time = data;
      CFG_REPEAT_DELAY:    regs.repeat_delay = data;
      CFG_REPEAT_INTERVAL: regs.repeat_interval = data;
      default: ;
    endcase
  endfunction

  function automatic cfg_t pick_regs(int kind);
    cfg_t c;
    case (kind)
      2: c = '0;
      4: c = '1;
      default: begin
        c.pin_mask = $urandom_range(0, 1) ? 16'd1 << $urandom_range(0, 15)
                                          : 16'($urandom_range(1, 65535));
        c.active_high = 1'($urandom_range(0, 1));
        c.debounce_time = 16'($urandom_range(0, 60));
        c.double_window = 16'($urandom_range(0, 500));
        c.long_press_time = 16'($urandom_range(0, 900));
        c.repeat_delay = 16'($urandom_range(0, 2000));
        c.repeat_interval = 16'($urandom_range(0, 600));
      end
    endcase
    return c;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic program_regs(cfg_t c);
    logic [ValW-1:0] vals [8];
    vals = '{c.pin_mask, {15'($urandom), c.active_high}, c.debounce_time,
             c.double_window, c.long_press_time, c.repeat_delay,
             c.repeat_interval, 16'($urandom)};
    for (int i = 0; i < 8; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= RegOrder[i];
      cfg_if.data <= vals[i];
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      apply_reg(RegOrder[i], vals[i]);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_tick(logic [ValW-1:0] elapsed, logic [ValW-1:0] port,
                           logic typed, logic [2:0] n_typed, ev_code_e first_ev);
    int n;
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.elapsed <= elapsed;
    in_if.port_value <= port;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    ticks_sent++;
    n = gesture_step(elapsed, port);
    if (typed) begin
      n = int'(n_typed);
      tick_ev[0] = first_ev;
    end
    for (int k = 0; k < n; k++) pending_events.push_back('{tick_ev[k], k == n - 1});
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_tick(inout bit want_press);
    logic [ValW-1:0] port;
    logic [ValW-1:0] sel;
    logic [ValW-1:0] elapsed;
    int              hi;
    int              r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_tick(16'($urandom), 16'($urandom), 1'b0, 3'd0, EV_RELEASE);
    end else begin
      if ($urandom_range(0, 7) == 0) want_press = !want_press;
      hi = (r < 28) ? int'(regs.repeat_delay) + 300 : int'(regs.debounce_time) + 40;
      if (hi > 65535) hi = 65535;
      elapsed = 16'($urandom_range(0, hi));
      port = 16'($urandom);
      sel = regs.pin_mask & 16'($urandom);
      if (sel == '0) sel = regs.pin_mask & (~regs.pin_mask + 16'd1);
      port = (want_press == regs.active_high) ? (port | sel) : (port & ~regs.pin_mask);
      send_tick(elapsed, port, 1'b0, 3'd0, EV_RELEASE);
    end
  endtask

  initial begin
    bit want_press;
    in_if.valid <= 1'b0;
    in_if.elapsed <= '0;
    in_if.port_value <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_PIN_MASK;
    cfg_if.data <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirectedTicks[i])
      send_tick(DirectedTicks[i].elapsed, DirectedTicks[i].port, DirectedTicks[i].typed,
                DirectedTicks[i].n_typed, DirectedTicks[i].first_ev);
    want_press = 1'b0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      program_regs(pick_regs(ph));
      calm = (ph == 1);
      for (int t = 0; t < TicksPerPhase; t++) begin
        if (ph == 5 && t == TicksPerPhase / 2) drain();
        random_tick(want_press);
      end
    end
    calm = 1'b0;
    drain();
    if (mismatches == 0) begin
      $display("PASS button_gesture_detector_unit");
    end else begin
      $display("FAIL button_gesture_detector_unit");
    end
    $finish;
  end

  initial begin
    int unsigned hold_left;
    bit          held;
    gesture_t    want;
    hold_left = 0;
    held = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("unexpected item, code %0d", out_if.event_code));
        end else begin
          want = pending_events.pop_front();
          if (out_if.event_code !== want.code)
            report_mismatch($sformatf("event_code %0d, want %s",
                                      out_if.event_code, want.code.name()));
          if (out_if.last_event !== want.last_ev)
            report_mismatch($sformatf("last_event %b, want %b",
                                      out_if.last_event, want.last_ev));
        end
      end
      if (!held && ticks_sent >= HoldAtTick) begin
        held = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WatchdogLimit) begin
        $display("FAIL button_gesture_detector_unit");
        $finish;
      end
    end
  end

endmodule
